FILE: rtl/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg: shared types and constants of the diffusion stencil
// Sample and coefficient formats, register codes and the records that pass
// between the line buffer, the window cells, the update pipe and the
// output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

  localparam int SAMPLE_W = 31;
  localparam int COEF_W   = 24;
  localparam int ACC_W    = 56;
  localparam int ROW_W    = 12;
  localparam int LAP_W    = SAMPLE_W + 2;
  localparam int PROD_W   = LAP_W + COEF_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd2;

  localparam int ROWS_MIN = 3;
  localparam int ROWS_MAX = 4096;
  localparam int COLS_MIN = 3;
  localparam int COLS_RST = 1024;

  localparam logic [COEF_W-1:0] COEF_RST      = 24'd16777;
  localparam logic [ROW_W-1:0]  ROWS_LAST_RST = 12'd1023;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t above;
    sample_t mid;
  } line_t;

  typedef struct packed {
    sample_t up;
    sample_t mid;
    sample_t down;
  } column_t;

  typedef struct packed {
    logic    first;
    logic    interior;
    logic    second;
    logic    last;
    sample_t echo;
  } tag_t;

  typedef struct packed {
    sample_t           value;
    logic              last;
    logic [ACC_W-1:0]  sum;
  } result_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

FILE: rtl/diffusion_stencil_5pt.sv
// ----------------------------------------------------------------------------
// diffusion_stencil_5pt: one explicit diffusion time step on a streamed grid
// Samples enter in raster order on sample/sample_valid/sample_stall; updated
// cells leave on new_value/frame_last/diff_sum with result_valid and
// result_stall, one row behind the input. Interior cells take the five
// point update, border cells pass through, and the last row also returns
// its own samples. diff_sum comes with frame_last on the final item.
// Registers are written on cfg_index/cfg_data when cfg_valid is high
// (cfg_ready is always high); the user must write them only while the block
// is idle, which the block does not enforce. A row or column count write
// restarts the frame. Throughput: one item per cycle while the output buffer
// has room, set by the single line buffer port pair; on the last row each
// item gives two results, so the output channel is slower than the input
// there. A result passes the read-ahead, window, laplacian, product, update
// and buffer registers after its item is accepted. A stalled receiver fills
// a four-item output buffer; sample_stall rises once three items wait in
// it. Reset empties the pipe and buffer, zeroes the frame position and sum
// and loads the default registers; the line buffer needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module diffusion_stencil_5pt import dfs_pkg::*; #(
  parameter int MAX_COLS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic [SAMPLE_W-1:0]  sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [SAMPLE_W-1:0]  new_value,
  output logic                 frame_last,
  output logic [ACC_W-1:0]     diff_sum
);

  localparam int CW = $clog2(MAX_COLS);
  localparam logic [CW-1:0] COLS_LAST_RST =
    CW'(((MAX_COLS < COLS_RST) ? MAX_COLS : COLS_RST) - 1);

  logic              cfg_wr;
  logic              geo_wr;
  logic [31:0]       row_req;
  logic [31:0]       col_req;
  logic [ROW_W-1:0]  row_last_req;
  logic [CW-1:0]     col_last_req;
  logic [COEF_W-1:0] coef;
  logic [ROW_W-1:0]  rows_last;
  logic [CW-1:0]     cols_last;

  logic              adv;
  logic              accept;
  logic [ROW_W-1:0]  row_pos;
  logic [CW-1:0]     col_pos;
  logic              col_end;
  logic              row_end;
  logic [CW-1:0]     col_next;
  tag_t              tag_in;

  line_t             rd;
  line_t             wr_line;

  logic              a_valid;
  tag_t              a_tag;
  logic              shift;
  logic              b_valid;
  tag_t              b_tag;
  column_t           win_l;
  column_t           win_c;
  column_t           win_r;
  column_t           win_r_in;
  column_t           win_c_in;

  push_t             push;
  result_t           res_a;
  result_t           res_b;
  result_t           out_item;

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign geo_wr    = cfg_wr && (cfg_index == REG_ROWS || cfg_index == REG_COLS);
  assign row_req   = 32'(cfg_data[ROW_W:0]);
  assign col_req   = 32'(cfg_data[10:0]);

  always_comb begin
    if (row_req < 32'(ROWS_MIN)) begin
      row_last_req = ROW_W'(ROWS_MIN - 1);
    end else if (row_req > 32'(ROWS_MAX)) begin
      row_last_req = ROW_W'(ROWS_MAX - 1);
    end else begin
      row_last_req = ROW_W'(row_req - 32'd1);
    end
    if (col_req < 32'(COLS_MIN)) begin
      col_last_req = CW'(COLS_MIN - 1);
    end else if (col_req > 32'(MAX_COLS)) begin
      col_last_req = CW'(MAX_COLS - 1);
    end else begin
      col_last_req = CW'(col_req - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef      <= COEF_RST;
      rows_last <= ROWS_LAST_RST;
      cols_last <= COLS_LAST_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_COEF: coef      <= cfg_data;
        REG_ROWS: rows_last <= row_last_req;
        REG_COLS: cols_last <= col_last_req;
        default:  ;
      endcase
    end
  end

  // input side and frame position
  assign sample_stall = !adv;
  assign accept       = sample_valid && !sample_stall;
  assign col_end      = (col_pos == cols_last);
  assign row_end      = (row_pos == rows_last);
  assign col_next     = col_end ? '0 : (col_pos + CW'(1));

  assign tag_in = '{
    first:    (row_pos != '0),
    interior: (row_pos >= ROW_W'(2)) && (col_pos != '0) && !col_end,
    second:   row_end,
    last:     col_end,
    echo:     sample
  };

  always_ff @(posedge clk) begin
    if (rst || geo_wr) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      col_pos <= col_next;
      if (col_end) begin
        row_pos <= row_end ? '0 : (row_pos + ROW_W'(1));
      end
    end
  end

  // line buffer: read ahead one column, write back the shifted pair
  assign wr_line = '{above: rd.mid, mid: sample};

  dfs_line_buf #(
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_pos),
    .wr_data (wr_line),
    .rd_en   (accept),
    .rd_addr (col_next),
    .rd_data (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_tag <= tag_in;
    end
    if (shift) begin
      b_tag <= a_tag;
    end
  end

  // window: right column from the read-ahead, centre gets the new sample
  assign shift    = adv && a_valid;
  assign win_r_in = '{up: rd.above, mid: rd.mid, down: '0};
  assign win_c_in = '{up: win_r.up, mid: win_r.mid, down: a_tag.echo};

  dfs_cell u_cell_r (
    .clk  (clk),
    .load (shift),
    .din  (win_r_in),
    .dout (win_r)
  );

  dfs_cell u_cell_c (
    .clk  (clk),
    .load (shift),
    .din  (win_c_in),
    .dout (win_c)
  );

  dfs_cell u_cell_l (
    .clk  (clk),
    .load (shift),
    .din  (win_c),
    .dout (win_l)
  );

  dfs_update u_update (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .clear    (geo_wr),
    .in_valid (b_valid),
    .in_tag   (b_tag),
    .left     (win_l),
    .centre   (win_c),
    .right    (win_r),
    .coef     (coef),
    .push     (push),
    .res_a    (res_a),
    .res_b    (res_b)
  );

  dfs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .room      (adv),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_item  (out_item)
  );

  assign new_value  = out_item.value;
  assign frame_last = out_item.last;
  assign diff_sum   = out_item.sum;

endmodule

`default_nettype wire

FILE: rtl/dfs_line_buf.sv
// ----------------------------------------------------------------------------
// dfs_line_buf: two-row line buffer
// One entry per column holds the two previous rows of that column; one
// write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_line_buf import dfs_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  line_t                    wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output line_t                    rd_data
);

  line_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dfs_cell.sv
// ----------------------------------------------------------------------------
// dfs_cell: one column of the 3x3 window
// Holds the up, middle and down samples of a column and takes the column at
// its input, a neighbour's or the read-ahead, on each window shift.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_cell import dfs_pkg::*; (
  input  logic    clk,
  input  logic    load,
  input  column_t din,
  output column_t dout
);

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dfs_update.sv
// ----------------------------------------------------------------------------
// dfs_update: stencil update pipe
// Laplacian magnitude, coefficient product with rounding, saturated new
// value and the running sum of absolute changes, one stage each.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_update import dfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              clear,
  input  logic              in_valid,
  input  tag_t              in_tag,
  input  column_t           left,
  input  column_t           centre,
  input  column_t           right,
  input  logic [COEF_W-1:0] coef,
  output push_t             push,
  output result_t           res_a,
  output result_t           res_b
);

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_W - 1);
  localparam logic [LAP_W:0]    SAT_MAX    = (LAP_W + 1)'({SAMPLE_W{1'b1}});

  logic [LAP_W-1:0]  pos;
  logic [LAP_W-1:0]  neg;
  logic              grow;
  logic [LAP_W-1:0]  lap_mag;

  logic              c_valid;
  tag_t              c_tag;
  logic [LAP_W-1:0]  c_mag;
  logic              c_grow;
  sample_t           c_ctr;

  logic [PROD_W-1:0] prod;
  logic              d_valid;
  tag_t              d_tag;
  logic [LAP_W-1:0]  d_step;
  logic              d_grow;
  sample_t           d_ctr;

  logic [LAP_W:0]    up_sum;
  sample_t           nv;
  sample_t           ad;
  logic              e_valid;
  tag_t              e_tag;
  sample_t           e_nv;
  sample_t           e_ad;

  logic [ACC_W-1:0]  acc;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_new;

  // four neighbours against four times the centre
  assign pos = LAP_W'(centre.up) + LAP_W'(centre.down) + LAP_W'(left.mid) + LAP_W'(right.mid);
  assign neg = {centre.mid, 2'b00};
  assign grow = (pos >= neg);
  assign lap_mag = grow ? (pos - neg) : (neg - pos);

  assign prod = PROD_W'(c_mag) * PROD_W'(coef) + ROUND_HALF;

  always_comb begin
    up_sum = (LAP_W + 1)'(d_ctr) + (LAP_W + 1)'(d_step);
    if (!d_tag.interior) begin
      nv = d_ctr;
    end else if (d_grow) begin
      nv = (up_sum > SAT_MAX) ? {SAMPLE_W{1'b1}} : up_sum[SAMPLE_W-1:0];
    end else begin
      nv = (d_step > LAP_W'(d_ctr)) ? '0 : (d_ctr - d_step[SAMPLE_W-1:0]);
    end
    ad = d_grow ? (nv - d_ctr) : (d_ctr - nv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= in_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_tag  <= in_tag;
      c_mag  <= lap_mag;
      c_grow <= grow;
      c_ctr  <= centre.mid;
      d_tag  <= c_tag;
      d_step <= prod[PROD_W-1:COEF_W];
      d_grow <= c_grow;
      d_ctr  <= c_ctr;
      e_tag  <= d_tag;
      e_nv   <= nv;
      e_ad   <= ad;
    end
  end

  // saturating sum of changes over interior cells
  assign acc_sum = (ACC_W + 1)'(acc) + (ACC_W + 1)'(e_ad);
  assign acc_new = !e_tag.interior ? acc : (acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
    end else if (adv && e_valid) begin
      acc <= (e_tag.second && e_tag.last) ? '0 : acc_new;
    end
  end

  assign push.first  = adv && e_valid && e_tag.first;
  assign push.second = adv && e_valid && e_tag.second;

  assign res_a = '{value: e_nv, last: 1'b0, sum: '0};
  assign res_b = '{value: e_tag.echo, last: e_tag.last, sum: e_tag.last ? acc_new : '0};

endmodule

`default_nettype wire

FILE: rtl/dfs_out_buf.sv
// ----------------------------------------------------------------------------
// dfs_out_buf: result buffer
// Small queue that takes up to two results a cycle and hands one a cycle
// to the output channel while it does not stall; reports room for two more.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_out_buf import dfs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  result_t res_a,
  input  result_t res_b,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_item
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  result_t         mem [DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   wp_inc;
  logic [PW-1:0]   rp;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] n_push;
  logic            pop;

  assign out_valid = (count != '0);
  assign out_item  = mem[rp];
  assign pop       = out_valid && !out_stall;
  assign n_push    = CNTW'(push.first) + CNTW'(push.second);
  assign wp_inc    = wp + PW'(1);
  assign room      = (count <= CNTW'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(n_push);
      rp    <= rp + PW'(pop);
      count <= count + n_push - CNTW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wp] <= res_a;
    end else if (push.second) begin
      mem[wp] <= res_b;
    end
    if (push.first && push.second) begin
      mem[wp_inc] <= res_b;
    end
  end

endmodule

`default_nettype wire
